FILE: rtl/core/max_window_sum_2d_core_macros.svh
// Assertion macros for the max window sum core.
// Included by the top level; needs nothing else.
`ifndef MAX_WINDOW_SUM_2D_CORE_MACROS_SVH
`define MAX_WINDOW_SUM_2D_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define MWS2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define MWS2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mws2d_pkg.sv
// Shared constants, types and codes of the max window sum core.
// Depends on nothing; imported by all but mws2d_ram and macros.
`timescale 1ns / 1ps

package mws2d_pkg;

  localparam int GRID_MAX   = 64;
  localparam int WIN_MAX    = 16;
  localparam int CELL_W     = 16;
  localparam int COL_W      = 20;
  localparam int SUM_W      = 24;
  localparam int GRID_W     = 7;
  localparam int WIN_W      = 5;
  localparam int IDX_W      = $clog2(GRID_MAX);
  localparam int ROWMOD_W   = $clog2(WIN_MAX);
  localparam int HIST_DEPTH = WIN_MAX * GRID_MAX;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int RESQ_DEPTH = 8;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE   = 2'd0,
    CFG_WINDOW_SIZE = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    COL_FIRST,
    COL_FILL,
    COL_SLIDE
  } col_mode_t;

  typedef struct packed {
    logic [CELL_W-1:0]             cell_val;
    logic [IDX_W-1:0]              col;
    logic [ROWMOD_W+IDX_W-1:0]     slot;
    col_mode_t                     mode;
    logic                          col0;
    logic                          ge_w;
    logic                          qual;
    logic                          last;
  } col_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] col_sum;
    logic [COL_W-1:0] tap;
    logic             col0;
    logic             ge_w;
    logic             qual;
    logic             last;
  } win_beat_t;

endpackage

FILE: rtl/core/mws2d_if.sv
// Channel interfaces of the max window sum core: cell input, result output, config write.
// Depends on mws2d_pkg.
`timescale 1ns / 1ps

interface mws2d_in_if;
  import mws2d_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface mws2d_out_if;
  import mws2d_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] best_total;
  modport source (output valid, output best_total, input ready);
  modport sink   (input valid, input best_total, output ready);
endinterface

interface mws2d_cfg_if;
  import mws2d_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mws2d_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mws2d_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mws2d_column.sv
// Grid position tracking, line store and column sum memory; emits column sums per cell.
// Depends on mws2d_pkg and mws2d_ram.
`timescale 1ns / 1ps

module mws2d_column (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_accept,
  input  logic [mws2d_pkg::CELL_W-1:0]      cell_val,
  input  logic                              restart,
  input  logic [mws2d_pkg::GRID_W-1:0]      g_eff,
  input  logic [mws2d_pkg::WIN_W-1:0]       w_eff,
  output logic                              pos_last,
  output logic                              win_valid,
  output mws2d_pkg::win_beat_t              win
);
  import mws2d_pkg::*;

  logic [IDX_W-1:0]    row_r, col_r;
  logic [ROWMOD_W-1:0] rmod_r;
  logic                col_last, row_last, rmod_last;
  col_beat_t           beat;
  logic                s1_valid_r;
  col_beat_t           s1_r;
  logic [CELL_W-1:0]   hist_rd;
  logic [COL_W-1:0]    cs_rd, cs_new;
  logic [COL_W-1:0]    line_r [WIN_MAX];
  logic [WIN_W-1:0]    w_m1;
  logic                win_valid_r;
  win_beat_t           win_r;

  always_comb begin
    col_last  = (GRID_W'(col_r) + GRID_W'(1)) == g_eff;
    row_last  = (GRID_W'(row_r) + GRID_W'(1)) == g_eff;
    rmod_last = (WIN_W'(rmod_r) + WIN_W'(1)) == w_eff;
    beat.cell_val = cell_val;
    beat.col  = col_r;
    beat.slot = {rmod_r, col_r};
    if (row_r == '0) begin
      beat.mode = COL_FIRST;
    end else if (GRID_W'(row_r) < GRID_W'(w_eff)) begin
      beat.mode = COL_FILL;
    end else begin
      beat.mode = COL_SLIDE;
    end
    beat.col0 = (col_r == '0);
    beat.ge_w = GRID_W'(col_r) >= GRID_W'(w_eff);
    beat.qual = ((GRID_W'(row_r) + GRID_W'(1)) >= GRID_W'(w_eff)) &&
                ((GRID_W'(col_r) + GRID_W'(1)) >= GRID_W'(w_eff));
    beat.last = col_last && row_last;
  end

  assign pos_last = beat.last;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r  <= '0;
      col_r  <= '0;
      rmod_r <= '0;
    end else if (in_accept) begin
      if (col_last) begin
        col_r <= '0;
        if (row_last) begin
          row_r  <= '0;
          rmod_r <= '0;
        end else begin
          row_r  <= row_r + IDX_W'(1);
          rmod_r <= rmod_last ? '0 : rmod_r + ROWMOD_W'(1);
        end
      end else begin
        col_r <= col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
    if (in_accept) begin
      s1_r <= beat;
    end
  end

  // consecutive cells never share a column unless the grid is one wide,
  // and then every cell starts its column, so no forwarding is needed
  mws2d_ram #(.WIDTH(CELL_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.slot),
    .wdata (s1_r.cell_val),
    .re    (in_accept),
    .raddr (beat.slot),
    .rdata (hist_rd)
  );

  mws2d_ram #(.WIDTH(COL_W), .DEPTH(GRID_MAX)) u_col_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.col),
    .wdata (cs_new),
    .re    (in_accept),
    .raddr (beat.col),
    .rdata (cs_rd)
  );

  always_comb begin
    case (s1_r.mode)
      COL_FIRST: cs_new = COL_W'(s1_r.cell_val);
      COL_FILL:  cs_new = cs_rd + COL_W'(s1_r.cell_val);
      COL_SLIDE: cs_new = cs_rd + COL_W'(s1_r.cell_val) - COL_W'(hist_rd);
      default:   cs_new = COL_W'(s1_r.cell_val);
    endcase
  end

  assign w_m1 = w_eff - WIN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
    end else begin
      win_valid_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      line_r[0] <= cs_new;
      for (int i = 1; i < WIN_MAX; i++) begin
        line_r[i] <= line_r[i-1];
      end
      win_r.col_sum <= cs_new;
      win_r.tap     <= line_r[w_m1[ROWMOD_W-1:0]];
      win_r.col0    <= s1_r.col0;
      win_r.ge_w    <= s1_r.ge_w;
      win_r.qual    <= s1_r.qual;
      win_r.last    <= s1_r.last;
    end
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;

endmodule

FILE: rtl/core/mws2d_window.sv
// Horizontal running block sum, best tracking and result queue.
// Depends on mws2d_pkg.
`timescale 1ns / 1ps

module mws2d_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  logic                              win_valid,
  input  mws2d_pkg::win_beat_t              win,
  input  logic                              pop,
  output logic                              res_valid,
  output logic [mws2d_pkg::SUM_W-1:0]       res_data,
  output logic [mws2d_pkg::RESQ_CNT_W-1:0]  q_cnt
);
  import mws2d_pkg::*;

  logic [SUM_W-1:0]      rw_r, rw_nxt;
  logic                  s3_valid_r, s3_qual_r, s3_last_r;
  logic [SUM_W-1:0]      best_r, best_pick;
  logic [SUM_W-1:0]      q_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [RESQ_CNT_W-1:0] q_cnt_r;
  logic                  push;

  always_comb begin
    rw_nxt = (win.col0 ? '0 : rw_r) + SUM_W'(win.col_sum) -
             (win.ge_w ? SUM_W'(win.tap) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= win_valid;
    end
    if (win_valid) begin
      rw_r      <= rw_nxt;
      s3_qual_r <= win.qual;
      s3_last_r <= win.last;
    end
  end

  assign best_pick = (s3_qual_r && (rw_r > best_r)) ? rw_r : best_r;
  assign push      = s3_valid_r && s3_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      best_r <= '0;
    end else if (s3_valid_r) begin
      best_r <= s3_last_r ? '0 : best_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + RESQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RESQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + RESQ_CNT_W'(1);
        2'b01:   q_cnt_r <= q_cnt_r - RESQ_CNT_W'(1);
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
    if (push) begin
      q_r[wr_ptr_r] <= best_pick;
    end
  end

  assign res_valid = (q_cnt_r != '0);
  assign res_data  = q_r[rd_ptr_r];
  assign q_cnt     = q_cnt_r;

endmodule

FILE: rtl/core/max_window_sum_2d_core.sv
// Max window sum core: largest sum over all square blocks of a streamed square grid.
// Channels: in_ch takes one cell_value per beat in row-major order; out_ch gives one
// best_total beat after the last cell of each grid; cfg_ch writes grid_size (index 0)
// and window_size (index 1), and either write starts a new grid. Write config only
// when no grid is in progress. A window larger than the grid yields 0.
// Throughput: one cell per cycle, limited by the single read-modify-write of the
// column sum memory and the line store per cell.
// The last cell's sum is registered in the column, window and sum stages, then queued.
// Results wait in an 8-entry queue; when 8 results are pending the last cell of
// the next grid is held off (in_ch.ready low) until out_ch takes a beat. Other
// cells keep flowing while out_ch stalls.
// Reset: synchronous, active low; grid_size and window_size return to 1 and the
// position restarts at the first cell. No memory clearing pass: every line store
// and column entry is written within a grid before it is read.
// Depends on mws2d_pkg, mws2d_if, mws2d_column, mws2d_window and the macro header.
`timescale 1ns / 1ps
`include "max_window_sum_2d_core_macros.svh"

module max_window_sum_2d_core (
  input  logic        clk,
  input  logic        rst_n,
  mws2d_in_if.sink    in_ch,
  mws2d_out_if.source out_ch,
  mws2d_cfg_if.sink   cfg_ch
);
  import mws2d_pkg::*;

  logic [GRID_W-1:0]     grid_size_r, g_eff;
  logic [WIN_W-1:0]      window_size_r, w_eff;
  logic                  restart;
  logic                  in_accept, out_pop, pos_last;
  logic                  win_valid;
  win_beat_t             win;
  logic [RESQ_CNT_W-1:0] pend_r, q_cnt;
  logic                  res_valid;
  logic [SUM_W-1:0]      res_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r   <= GRID_W'(1);
      window_size_r <= WIN_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_GRID_SIZE:   grid_size_r   <= cfg_ch.data[GRID_W-1:0];
        CFG_WINDOW_SIZE: window_size_r <= cfg_ch.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_t'(cfg_ch.index))
      CFG_GRID_SIZE, CFG_WINDOW_SIZE: restart = cfg_ch.valid;
      default:                        restart = 1'b0;
    endcase
  end

  always_comb begin
    if (grid_size_r == '0) begin
      g_eff = GRID_W'(1);
    end else if (grid_size_r > GRID_W'(GRID_MAX)) begin
      g_eff = GRID_W'(GRID_MAX);
    end else begin
      g_eff = grid_size_r;
    end
    if (window_size_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_size_r > WIN_W'(WIN_MAX)) begin
      w_eff = WIN_W'(WIN_MAX);
    end else begin
      w_eff = window_size_r;
    end
  end

  assign in_ch.ready = !pos_last || (pend_r < RESQ_CNT_W'(RESQ_DEPTH));
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_pop     = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_accept && pos_last, out_pop})
        2'b10:   pend_r <= pend_r + RESQ_CNT_W'(1);
        2'b01:   pend_r <= pend_r - RESQ_CNT_W'(1);
        default: pend_r <= pend_r;
      endcase
    end
  end

  mws2d_column u_column (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .cell_val  (in_ch.cell_value),
    .restart   (restart),
    .g_eff     (g_eff),
    .w_eff     (w_eff),
    .pos_last  (pos_last),
    .win_valid (win_valid),
    .win       (win)
  );

  mws2d_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .win_valid (win_valid),
    .win       (win),
    .pop       (out_pop),
    .res_valid (res_valid),
    .res_data  (res_data),
    .q_cnt     (q_cnt)
  );

  assign out_ch.valid      = res_valid;
  assign out_ch.best_total = res_data;

  `MWS2D_ASSERT_NOW(a_pend_bound, clk, rst_n, 1'b1, pend_r <= RESQ_CNT_W'(RESQ_DEPTH), "pending results exceed queue depth")
  `MWS2D_ASSERT_NOW(a_queue_le_pend, clk, rst_n, 1'b1, q_cnt <= pend_r, "queue holds more results than were counted")
  `MWS2D_ASSERT_NOW(a_out_has_pend, clk, rst_n, out_ch.valid, pend_r != '0, "result offered with no pending grid")
  `MWS2D_ASSERT_NEXT(a_pend_incr, clk, rst_n, in_accept && pos_last && !out_pop, pend_r == $past(pend_r) + RESQ_CNT_W'(1), "last cell not counted as pending")

endmodule
